>>> design/pals_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Oscillator shaper package
// Shared types, codes and stream layout of the phase accumulator shaper.
// ----------------------------------------------------------------------------
package pals_pkg;

    // Stream widths and field positions.
    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;
    localparam int TIDX_LSB  = 0;
    localparam int TVAL_LSB  = 8;
    localparam int ENV_LSB   = 24;
    localparam int ACT_BIT   = 40;

    // Item kinds carried in s_tuser.
    localparam logic [1:0] MODE_TICK     = 2'd0;
    localparam logic [1:0] MODE_WR_RIGHT = 2'd1;
    localparam logic [1:0] MODE_WR_LEFT  = 2'd2;
    localparam logic [1:0] MODE_NONE     = 2'd3;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam logic [CFG_INDEX_W-1:0] REG_PHASE_INC = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_VELOCITY  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_VEL_SENS  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_VOLUME    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_TABLE_LEN = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SHAPER_EN = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_POS,
        ST_IDX,
        ST_RDA,
        ST_RDB,
        ST_INT,
        ST_MUL,
        ST_OUT,
        ST_ZERO
    } pals_state_t;

    typedef struct packed {
        logic accept;
        logic st_pos;
        logic st_idx;
        logic st_rda;
        logic st_rdb;
        logic st_int;
        logic st_mul;
        logic out_load;
        logic out_zero;
        logic phase_adv;
    } pals_cmd_t;

    typedef struct packed {
        logic [1:0] in_mode;
        logic       in_active;
    } pals_status_t;

endpackage
`default_nettype wire

>>> design/phase_accumulator_lut_shaper_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Phase accumulator oscillator with interpolated wave shaper
// Top level: joins the sequencing controller and the arithmetic datapath.
// ----------------------------------------------------------------------------
// The input stream carries one item per transfer. s_tuser holds the item
// kind: a sample tick, a right table write or a left table write. A table
// write stores table_value at table_index and gives no result. A tick with
// env_active low returns a zero sample and leaves the phase alone; an active
// tick returns one shaped, scaled and saturated sample on the output stream
// and then advances the phase by the phase increment. The user must write
// configuration via cfg_wr only while idle; the block does not enforce it.
//
// Sequencing: a table write completes on its transfer and the block stays
// idle. An inactive tick passes through the zero step only. An active tick
// runs from its transfer to m_tvalid through the controller's seven step
// sequence (position, index, two reads through the single read port of
// each table with the slope product on the second, interpolation, gain
// multiply and the output load). s_tready is high only between items, so
// the block takes no new item until the previous one has left its last step.
// The result sits in an output register; the block takes the next item
// while it waits. If the receiver stalls, a following tick holds in its
// last step until the register frees. Reset clears the phase and all
// control state and sets the configuration defaults; tables are not cleared.
// ----------------------------------------------------------------------------
module phase_accumulator_lut_shaper_top
    import pals_pkg::*;
#(
    parameter int LUT_SIZE = 256
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // Input stream.
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // Fields from bit 0: table_index[7:0], table_value[15:0],
    // env_value[15:0], env_active, zero fill to 48 bits.
    input  wire logic [S_TDATA_W-1:0]   s_tdata,
    // Fields from bit 0: mode[1:0].
    input  wire logic [S_TUSER_W-1:0]   s_tuser,
    // Result stream.
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // Fields from bit 0: sample_out[15:0].
    output logic      [M_TDATA_W-1:0]   m_tdata,
    // Configuration write port.
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_wr_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wr_data
);

    // The controller and the datapath talk only through these two groups.
    pals_cmd_t    cmd;
    pals_status_t status;

    pals_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the configuration, the phase, both tables and the
    // output sample register.
    pals_datapath #(
        .LUT_SIZE (LUT_SIZE)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tdata      (m_tdata),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .cmd          (cmd),
        .status       (status)
    );

endmodule
`default_nettype wire

>>> design/pals_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pals_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

>>> design/pals_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Oscillator shaper controller
// Sequences each item through the datapath and owns the output valid flag.
// ----------------------------------------------------------------------------
module pals_ctrl
    import pals_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic         m_tready,
    output logic              m_tvalid,
    input  wire pals_status_t status,
    output pals_cmd_t         cmd
);

    pals_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    if (status.in_mode == MODE_TICK) begin
                        state_next = status.in_active ? ST_POS : ST_ZERO;
                    end
                end
            end
            ST_POS: begin
                cmd.st_pos = 1'b1;
                state_next = ST_IDX;
            end
            ST_IDX: begin
                cmd.st_idx = 1'b1;
                state_next = ST_RDA;
            end
            ST_RDA: begin
                cmd.st_rda = 1'b1;
                state_next = ST_RDB;
            end
            ST_RDB: begin
                cmd.st_rdb = 1'b1;
                state_next = ST_INT;
            end
            ST_INT: begin
                cmd.st_int = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.st_mul = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    cmd.out_load  = 1'b1;
                    cmd.phase_adv = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_ZERO: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_zero = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

endmodule
`default_nettype wire

>>> design/pals_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Oscillator shaper datapath
// Configuration, phase, wave tables, interpolation and gain arithmetic.
// ----------------------------------------------------------------------------
module pals_datapath
    import pals_pkg::*;
#(
    parameter int LUT_SIZE = 256
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic [S_TDATA_W-1:0]   s_tdata,
    input  wire logic [S_TUSER_W-1:0]   s_tuser,
    output logic      [M_TDATA_W-1:0]   m_tdata,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_wr_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wr_data,
    input  wire pals_cmd_t              cmd,
    output pals_status_t                status
);

    localparam int AW = $clog2(LUT_SIZE);

    // Input fields.
    logic [7:0]  in_index;
    logic [15:0] in_value;
    logic [15:0] in_env;
    logic        in_range;

    assign in_index = s_tdata[TIDX_LSB +: 8];
    assign in_value = s_tdata[TVAL_LSB +: 16];
    assign in_env   = s_tdata[ENV_LSB +: 16];
    assign in_range = (32'(in_index) < LUT_SIZE);

    assign status.in_mode   = s_tuser;
    assign status.in_active = s_tdata[ACT_BIT];

    // Configuration registers.
    logic [31:0] phase_inc_reg;
    logic [15:0] velocity_reg;
    logic [15:0] sens_reg;
    logic [15:0] volume_reg;
    logic [8:0]  tlen_reg;
    logic        shaper_en_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_inc_reg <= 32'd0;
            velocity_reg  <= 16'hFFFF;
            sens_reg      <= 16'd0;
            volume_reg    <= 16'hFFFF;
            tlen_reg      <= 9'd256;
            shaper_en_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_PHASE_INC: phase_inc_reg <= cfg_wr_data;
                REG_VELOCITY:  velocity_reg  <= cfg_wr_data[15:0];
                REG_VEL_SENS:  sens_reg      <= cfg_wr_data[15:0];
                REG_VOLUME:    volume_reg    <= cfg_wr_data[15:0];
                REG_TABLE_LEN: tlen_reg      <= cfg_wr_data[8:0];
                REG_SHAPER_EN: shaper_en_reg <= cfg_wr_data[0];
                default: begin
                end
            endcase
        end
    end

    // Phase accumulator.
    logic [31:0] phase_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= 32'd0;
        end else if (cmd.phase_adv) begin
            phase_reg <= phase_reg + phase_inc_reg;
        end
    end

    // Table length in use, held to the range two to LUT_SIZE.
    logic [8:0] len_c;
    logic [8:0] len_m1;
    logic [8:0] len_m2;

    always_comb begin
        if (tlen_reg < 9'd2) begin
            len_c = 9'd2;
        end else if (32'(tlen_reg) > LUT_SIZE) begin
            len_c = 9'(LUT_SIZE);
        end else begin
            len_c = tlen_reg;
        end
    end

    assign len_m1 = len_c - 9'd1;
    assign len_m2 = len_c - 9'd2;

    // Wave tables.
    logic [AW-1:0]     rd_addr;
    logic [15:0]       rdata_right;
    logic [15:0]       rdata_left;
    logic [8:0]        idx_c;
    logic [8:0]        idx_reg;

    assign rd_addr = cmd.st_idx ? AW'(idx_c) : AW'(idx_reg + 9'd1);

    pals_ram #(
        .WIDTH (16),
        .DEPTH (LUT_SIZE)
    ) u_right_ram (
        .aclk  (aclk),
        .we    (cmd.accept && (s_tuser == MODE_WR_RIGHT) && in_range),
        .waddr (AW'(in_index)),
        .wdata (in_value),
        .raddr (rd_addr),
        .rdata (rdata_right)
    );

    pals_ram #(
        .WIDTH (16),
        .DEPTH (LUT_SIZE)
    ) u_left_ram (
        .aclk  (aclk),
        .we    (cmd.accept && (s_tuser == MODE_WR_LEFT) && in_range),
        .waddr (AW'(in_index)),
        .wdata (in_value),
        .raddr (rd_addr),
        .rdata (rdata_left)
    );

    // Step one: table position and the velocity blend.
    logic [15:0] env_reg;
    logic        right_reg;
    logic [31:0] mag;
    logic [40:0] pos_reg;
    logic [31:0] sv_prod;
    logic [32:0] ev_reg;

    assign mag = phase_reg[31] ? {1'b0, phase_reg[30:0]}
                               : (32'h8000_0000 - {1'b0, phase_reg[30:0]});
    assign sv_prod = 32'(sens_reg) * 32'(velocity_reg);

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            env_reg <= in_env;
        end
        if (cmd.st_pos) begin
            right_reg <= phase_reg[31];
            pos_reg   <= {9'd0, mag} * {32'd0, len_m1};
            ev_reg    <= {(17'h10000 - {1'b0, sens_reg}), 16'h0000} + {1'b0, sv_prod};
        end
    end

    // Step two: entry index, fraction and amplitude.
    logic [9:0]  pos_hi;
    logic [40:0] frac_full;
    logic [31:0] frac_reg;
    logic [48:0] ev_vol;
    logic [48:0] ev_vol_rnd;
    logic [16:0] amp_reg;

    assign pos_hi     = pos_reg[40:31];
    assign idx_c      = ({1'b0, len_m2} < pos_hi) ? len_m2 : pos_hi[8:0];
    assign frac_full  = pos_reg - {1'b0, idx_c, 31'd0};
    assign ev_vol     = 49'(ev_reg) * 49'(volume_reg);
    assign ev_vol_rnd = ev_vol + 49'h0_8000_0000;

    always_ff @(posedge aclk) begin
        if (cmd.st_idx) begin
            idx_reg  <= idx_c;
            frac_reg <= frac_full[31:0];
            amp_reg  <= ev_vol_rnd[48:32];
        end
    end

    // Steps three and four: both neighbor entries, slope product and gain.
    logic signed [15:0] rd_sel;
    logic signed [15:0] a_reg;
    logic signed [16:0] diff;
    logic signed [49:0] prod_reg;
    logic        [32:0] gain_reg;

    assign rd_sel = right_reg ? $signed(rdata_right) : $signed(rdata_left);
    assign diff   = 17'(rd_sel) - 17'(a_reg);

    always_ff @(posedge aclk) begin
        if (cmd.st_rda) begin
            a_reg <= rd_sel;
        end
        if (cmd.st_rdb) begin
            prod_reg <= 50'($signed({1'b0, frac_reg})) * 50'(diff);
            gain_reg <= 33'(amp_reg) * 33'(env_reg);
        end
    end

    // Step five: interpolated value, sign of x, or the bypass value.
    logic signed [50:0] prod_rnd;
    logic signed [19:0] slope_step;
    logic signed [17:0] interp;
    logic signed [15:0] bypass;
    logic signed [17:0] y_reg;

    assign prod_rnd   = 51'(prod_reg) + 51'sh4000_0000;
    assign slope_step = $signed(prod_rnd[50:31]);
    assign interp     = 18'(a_reg) + 18'(slope_step);
    assign bypass     = $signed({~phase_reg[31], phase_reg[30:16]});

    always_ff @(posedge aclk) begin
        if (cmd.st_int) begin
            if (!shaper_en_reg) begin
                y_reg <= 18'(bypass);
            end else if (right_reg) begin
                y_reg <= interp;
            end else begin
                y_reg <= -interp;
            end
        end
    end

    // Step six: apply gain. Last step: round, saturate and load the output.
    logic signed [51:0] mul_reg;
    logic signed [52:0] mul_rnd;
    logic signed [20:0] r_val;
    logic signed [15:0] sat_val;
    logic        [15:0] out_reg;

    assign mul_rnd = 53'(mul_reg) + 53'sh8000_0000;
    assign r_val   = $signed(mul_rnd[52:32]);

    always_comb begin
        if (r_val > 21'sd32767) begin
            sat_val = 16'sh7FFF;
        end else if (r_val < -21'sd32768) begin
            sat_val = -16'sh8000;
        end else begin
            sat_val = r_val[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.st_mul) begin
            mul_reg <= 52'(y_reg) * 52'($signed({1'b0, gain_reg}));
        end
        if (cmd.out_load) begin
            out_reg <= cmd.out_zero ? 16'd0 : sat_val;
        end
    end

    assign m_tdata = out_reg;

endmodule
`default_nettype wire

>>> design/pals_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Oscillator shaper checker
// Port level checks on item sequencing, attached to the top level by bind.
// ----------------------------------------------------------------------------
module pals_checker
    import pals_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic [S_TDATA_W-1:0] s_tdata,
    input wire logic [S_TUSER_W-1:0] s_tuser,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata
);

    logic tick_xfer;

    assign tick_xfer = s_tvalid && s_tready && (s_tuser == MODE_TICK);

    // A stalled result holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // An active tick keeps the input closed until its last step.
    a_tick_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        tick_xfer && s_tdata[ACT_BIT] |-> ##7 !s_tready)
        else $error("input reopened before the active tick finished");

    // An inactive tick on an empty output gives a zero sample.
    a_zero_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        tick_xfer && !s_tdata[ACT_BIT] && !m_tvalid |-> ##2
        (m_tvalid && (m_tdata == '0)))
        else $error("inactive tick did not give a zero sample");

    // A new result appears only while an item is in work.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared with no item in work");

endmodule

bind phase_accumulator_lut_shaper_top pals_checker u_pals_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
